FILE: sv/btpc_pkg.sv
// Shared types and constants for the barometric compensation pipeline.
// No dependencies; used by btpc_wmul and baro_temp_pressure_compensation.
`default_nettype none

package btpc_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP       = 2'd0,
    CFG_PRESS_GAIN = 2'd1,
    CFG_PRESS_OFFS = 2'd2,
    CFG_PRESS_HIGH = 2'd3
  } cfg_idx_t;

  // Calibration register widths
  localparam int TCAL_W = 40;
  localparam int PGCAL_W = 48;
  localparam int POCAL_W = 48;
  localparam int PHCAL_W = 32;

  // Offset removed from the P1 and P2 coefficients
  localparam logic signed [16:0] P_COEF_OFFSET = 17'sd16384;

  // Result ranges
  localparam logic signed [23:0] TEMP_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] TEMP_MIN = 24'sh800000;
  localparam logic [24:0]        PRES_MAX = 25'h1FFFFFF;

  // Wide multiplier defaults
  localparam int MUL_CHUNK  = 32;
  localparam int WMUL_XW    = 64;
  localparam int WMUL_YW    = 28;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } in_t;

  typedef struct packed {
    logic signed [23:0] temperature_out;
    logic [24:0]        pressure_out;
    logic               clamped;
  } out_t;

endpackage

`default_nettype wire

FILE: sv/baro_temp_pressure_compensation.sv
// Barometric temperature/pressure compensation, ten-stage pipeline.
// Throughput one transaction per cycle while the output is not stalled, set by
// the fully pipelined multiplier stages. Empty stages refill while the output
// is stalled. Synchronous active-low reset clears all stage valid bits and the
// calibration registers. Uses btpc_pkg and btpc_wmul.
`default_nettype none

module baro_temp_pressure_compensation import btpc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire in_t                    in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output out_t                        out_data,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int NS   = 10;
  localparam int TQN  = 5;
  localparam int DW   = 25;
  localparam int UW   = 25;
  localparam int MW   = 41;
  localparam int DDW  = 48;
  localparam int EW   = 56;
  localparam int TNW  = 60;
  localparam int TLW  = 28;
  localparam int QW   = 34;
  localparam int AW   = 37;
  localparam int RW   = 58;
  localparam int BW   = 61;
  localparam int SW   = 63;
  localparam int C0W  = 88;
  localparam int C1W  = 62;
  localparam int C2W  = 33;
  localparam int C3W  = 33;
  localparam int V1W  = 61;
  localparam int V2W  = 89;
  localparam int V3W  = 117;
  localparam int PRW  = V3W - 77;

  localparam logic signed [TNW-1:0] TN_RND = {{(TNW-32){1'b0}}, 1'b1, 31'b0};
  localparam logic signed [V3W-1:0] P_RND  = {{(V3W-77){1'b0}}, 1'b1, 76'b0};

  // Calibration registers
  logic [TCAL_W-1:0]  tcal_r;
  logic [PGCAL_W-1:0] pgcal_r;
  logic [POCAL_W-1:0] pocal_r;
  logic [PHCAL_W-1:0] phcal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcal_r  <= '0;
      pgcal_r <= '0;
      pocal_r <= '0;
      phcal_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TEMP:       tcal_r  <= cfg_data[TCAL_W-1:0];
        CFG_PRESS_GAIN: pgcal_r <= cfg_data[PGCAL_W-1:0];
        CFG_PRESS_OFFS: pocal_r <= cfg_data[POCAL_W-1:0];
        CFG_PRESS_HIGH: phcal_r <= cfg_data[PHCAL_W-1:0];
        default:        tcal_r  <= tcal_r;
      endcase
    end
  end

  // Decode coefficients from the little-endian calibration bytes
  logic [15:0]        t1;
  logic signed [16:0] t2s;
  logic signed [7:0]  t3;
  logic signed [16:0] p1, p2;
  logic signed [7:0]  p3, p4, p7, p8, p10, p11;
  logic signed [16:0] p5s, p6s;
  logic signed [15:0] p9;

  assign t1  = tcal_r[15:0];
  assign t2s = $signed({1'b0, tcal_r[31:16]});
  assign t3  = $signed(tcal_r[39:32]);
  assign p1  = 17'($signed(pgcal_r[15:0])) - P_COEF_OFFSET;
  assign p2  = 17'($signed(pgcal_r[31:16])) - P_COEF_OFFSET;
  assign p3  = $signed(pgcal_r[39:32]);
  assign p4  = $signed(pgcal_r[47:40]);
  assign p5s = $signed({1'b0, pocal_r[15:0]});
  assign p6s = $signed({1'b0, pocal_r[31:16]});
  assign p7  = $signed(pocal_r[39:32]);
  assign p8  = $signed(pocal_r[47:40]);
  assign p9  = $signed(phcal_r[15:0]);
  assign p10 = $signed(phcal_r[23:16]);
  assign p11 = $signed(phcal_r[31:24]);

  // Stage valid bits and advance enables; a stage moves when it is empty
  // or the stage after it moves
  logic [NS-1:0] vld_r;
  logic [NS-1:0] adv;
  logic [NS-1:0] vld_in;

  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int j = NS - 2; j >= 0; j--) begin
      adv[j] = !vld_r[j] || adv[j+1];
    end
  end

  assign vld_in = {vld_r[NS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int j = 0; j < NS; j++) begin
        if (adv[j]) begin
          vld_r[j] <= vld_in[j];
        end
      end
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[NS-1];

  // Stage 1: temperature difference and first coefficient products in u
  logic signed [UW-1:0]  u_in;
  logic signed [DW-1:0]  d_s1_r;
  logic signed [UW-1:0]  u_s1_r, u_s2_r, u_s3_r;
  logic signed [QW-1:0]  q_s1_r;
  logic signed [AW-1:0]  a_s1_r;
  logic signed [C2W-1:0] c2_s1_r, c2_s2_r, c2_s3_r, c2_s4_r;
  logic signed [C3W-1:0] c3_s1_r, c3_s2_r, c3_s3_r, c3_s4_r;

  assign u_in = $signed({1'b0, in_data.raw_pressure});

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      d_s1_r  <= DW'($signed({2'b0, in_data.raw_temperature}) - $signed({2'b0, t1, 8'b0}));
      u_s1_r  <= u_in;
      q_s1_r  <= (QW'(p9) <<< 17) + QW'(u_in) * QW'(p11);
      a_s1_r  <= (AW'(p2) <<< 19) + AW'(u_in) * AW'(p10);
      c2_s1_r <= (C2W'(p7) <<< 24) + C2W'(u_in) * C2W'(p3);
      c3_s1_r <= (C3W'(p8) <<< 22) + C3W'(u_in) * C3W'(p4);
    end
  end

  // Stage 2: linear and square temperature terms, second products in u
  logic signed [MW-1:0]  m_s2_r, m_s3_r;
  logic [DDW-1:0]        dd_s2_r;
  logic signed [RW-1:0]  r_s2_r;
  logic signed [BW-1:0]  b_s2_r;
  logic signed [2*DW-1:0] dd_full;

  assign dd_full = (2*DW)'(d_s1_r) * (2*DW)'(d_s1_r);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      m_s2_r  <= MW'(d_s1_r) * MW'(t2s);
      dd_s2_r <= dd_full[DDW-1:0];
      r_s2_r  <= RW'(u_s1_r) * RW'(q_s1_r);
      b_s2_r  <= BW'(u_s1_r) * BW'(a_s1_r);
      u_s2_r  <= u_s1_r;
      c2_s2_r <= c2_s1_r;
      c3_s2_r <= c3_s1_r;
    end
  end

  // Stage 3: square term gain, close the u polynomials of the low coefficients
  logic signed [EW-1:0]  e_s3_r;
  logic signed [SW-1:0]  s_s3_r;
  logic signed [C1W-1:0] c1_s3_r, c1_s4_r, c1_s5_r, c1_s6_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      e_s3_r  <= EW'($signed({1'b0, dd_s2_r})) * EW'(t3);
      m_s3_r  <= m_s2_r;
      s_s3_r  <= (SW'(p1) <<< 45) + SW'(r_s2_r);
      c1_s3_r <= (C1W'(p6s) <<< 42) + C1W'(b_s2_r);
      u_s3_r  <= u_s2_r;
      c2_s3_r <= c2_s2_r;
      c3_s3_r <= c3_s2_r;
    end
  end

  // Stage 4: rounded linear temperature; u times constant-term polynomial
  logic signed [TNW-1:0] tn;
  logic signed [TLW-1:0] tl_s4_r, tl_s5_r, tl_s6_r, tl_s7_r;
  logic signed [C0W-1:0] w_prod;

  assign tn = (TNW'(m_s3_r) <<< 18) + TNW'(e_s3_r) + TN_RND;

  btpc_wmul #(.XW(SW), .YW(UW)) u_wmul_c0 (
    .clk  (clk),
    .en   (adv[3]),
    .x    (s_s3_r),
    .y    (u_s3_r),
    .prod (w_prod)
  );

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      tl_s4_r <= tn[TNW-1:32];
      c1_s4_r <= c1_s3_r;
      c2_s4_r <= c2_s3_r;
      c3_s4_r <= c3_s3_r;
    end
  end

  // Stage 5: first Horner step in temperature, clamp temperature
  logic signed [V1W-1:0] v1_s5_r;
  logic signed [C0W-1:0] c0_s5_r, c0_s6_r, c0_s7_r, c0_s8_r;
  logic                  t_over, t_under;
  logic signed [23:0]    tq_nxt;
  logic signed [23:0]    tq_r [TQN];
  logic                  tc_r [TQN];

  assign t_over  = !tl_s4_r[TLW-1] && (|tl_s4_r[TLW-2:23]);
  assign t_under = tl_s4_r[TLW-1] && !(&tl_s4_r[TLW-2:23]);

  always_comb begin
    priority if (t_over) begin
      tq_nxt = TEMP_MAX;
    end else if (t_under) begin
      tq_nxt = TEMP_MIN;
    end else begin
      tq_nxt = tl_s4_r[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      v1_s5_r <= V1W'(c3_s4_r) * V1W'(tl_s4_r) + (V1W'(c2_s4_r) <<< 21);
      c0_s5_r <= (C0W'(p5s) <<< 68) + w_prod;
      c1_s5_r <= c1_s4_r;
      tl_s5_r <= tl_s4_r;
    end
  end

  // Carry the clamped temperature alongside stages 5 to 9
  always_ff @(posedge clk) begin
    for (int i = 0; i < TQN; i++) begin
      if (adv[4+i]) begin
        if (i == 0) begin
          tq_r[i] <= tq_nxt;
          tc_r[i] <= t_over || t_under;
        end else begin
          tq_r[i] <= tq_r[i-1];
          tc_r[i] <= tc_r[i-1];
        end
      end
    end
  end

  // Stages 6 and 7: second Horner step
  logic signed [V2W-1:0] v2_prod;
  logic signed [V2W-1:0] v2_s7_r;

  btpc_wmul #(.XW(V1W), .YW(TLW)) u_wmul_v2 (
    .clk  (clk),
    .en   (adv[5]),
    .x    (v1_s5_r),
    .y    (tl_s5_r),
    .prod (v2_prod)
  );

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      tl_s6_r <= tl_s5_r;
      c1_s6_r <= c1_s5_r;
      c0_s6_r <= c0_s5_r;
    end
    if (adv[6]) begin
      v2_s7_r <= v2_prod + (V2W'(c1_s6_r) <<< 21);
      tl_s7_r <= tl_s6_r;
      c0_s7_r <= c0_s6_r;
    end
  end

  // Stages 8 and 9: last Horner step plus rounding offset
  logic signed [V3W-1:0] v3_prod;
  logic signed [V3W-1:0] v3_s9_r;

  btpc_wmul #(.XW(V2W), .YW(TLW)) u_wmul_v3 (
    .clk  (clk),
    .en   (adv[7]),
    .x    (v2_s7_r),
    .y    (tl_s7_r),
    .prod (v3_prod)
  );

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      c0_s8_r <= c0_s7_r;
    end
    if (adv[8]) begin
      v3_s9_r <= v3_prod + (V3W'(c0_s8_r) <<< 20) + P_RND;
    end
  end

  // Stage 10: scale to 1/256 Pa, clamp, and hold the result
  logic signed [PRW-1:0] pr;
  logic                  p_under, p_over;
  out_t                  out_r, out_nxt;

  assign pr      = v3_s9_r[V3W-1:77];
  assign p_under = pr[PRW-1];
  assign p_over  = !pr[PRW-1] && (|pr[PRW-2:25]);

  always_comb begin
    out_nxt.temperature_out = tq_r[TQN-1];
    priority if (p_under) begin
      out_nxt.pressure_out = '0;
    end else if (p_over) begin
      out_nxt.pressure_out = PRES_MAX;
    end else begin
      out_nxt.pressure_out = pr[24:0];
    end
    out_nxt.clamped = tc_r[TQN-1] || p_under || p_over;
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  // An accepted transaction lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted transaction missing from first stage");

  // An empty first stage never stalls the input
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> !in_stall)
    else $error("input stalled with empty first stage");

  // The clamp flag only accompanies a saturated result
  a_clamp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.temperature_out != TEMP_MAX &&
     out_data.temperature_out != TEMP_MIN && out_data.pressure_out != '0 &&
     out_data.pressure_out != PRES_MAX) |-> !out_data.clamped)
    else $error("clamp flag set on an unsaturated result");

endmodule

`default_nettype wire

FILE: sv/btpc_wmul.sv
// Wide signed by narrow signed multiplier, split into 32-bit chunk products.
// Chunk products are registered; their shifted sum is combinational. Uses btpc_pkg.
`default_nettype none

module btpc_wmul import btpc_pkg::*; #(
  parameter int XW = WMUL_XW,
  parameter int YW = WMUL_YW
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic signed [XW-1:0]   x,
  input  wire logic signed [YW-1:0]   y,
  output logic signed [XW+YW-1:0]     prod
);

  localparam int CW  = MUL_CHUNK;
  localparam int NC  = (XW + CW - 1) / CW;
  localparam int EXW = NC * CW;
  localparam int PW  = CW + 1 + YW;
  localparam int RW  = XW + YW;

  logic signed [EXW-1:0] xe;
  logic signed [PW-1:0]  pp_nxt [NC];
  logic signed [PW-1:0]  pp_r   [NC];
  logic signed [RW-1:0]  acc;

  assign xe = EXW'(x);

  // Form one product per chunk: low chunks unsigned, top chunk signed
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      if (i == NC - 1) begin
        pp_nxt[i] = PW'($signed({xe[i*CW+CW-1], xe[i*CW +: CW]})) * PW'(y);
      end else begin
        pp_nxt[i] = PW'($signed({1'b0, xe[i*CW +: CW]})) * PW'(y);
      end
    end
  end

  // Hold chunk products while the stage is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NC; i++) begin
        pp_r[i] <= pp_nxt[i];
      end
    end
  end

  // Align and add chunk products
  always_comb begin
    acc = '0;
    for (int i = 0; i < NC; i++) begin
      acc = acc + (RW'(pp_r[i]) <<< (i * CW));
    end
  end

  assign prod = acc;

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for baro_temp_pressure_compensation.
// Drives sample pairs under zero, fixed and random calibration sets and predicts each result in
// wide signed arithmetic. Depends on btpc_pkg and the compensation RTL.
`timescale 1ns / 100ps

module testbench;
  import btpc_pkg::*;

  typedef logic signed [159:0] wide_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 16;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Calibration shadow copy
  logic [TCAL_W-1:0]  temp_cal;
  logic [PGCAL_W-1:0] gain_cal;
  logic [POCAL_W-1:0] offs_cal;
  logic [PHCAL_W-1:0] high_cal;

  out_t expected_results[$];
  int   mismatches;
  int   quiet_cycles;
  bit   gaps_on;

  baro_temp_pressure_compensation DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Compute compensated temperature and pressure for one sample pair
  function automatic out_t compensate(in_t s);
    longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    longint u, d, tn, tl, tl2, u2;
    wide_t tl3, acc, pres;
    out_t r;
    bit clip;
    t1  = longint'(temp_cal[15:0]);
    t2  = longint'(temp_cal[31:16]);
    t3  = longint'($signed(temp_cal[39:32]));
    p1  = longint'($signed(gain_cal[15:0])) - 16384;
    p2  = longint'($signed(gain_cal[31:16])) - 16384;
    p3  = longint'($signed(gain_cal[39:32]));
    p4  = longint'($signed(gain_cal[47:40]));
    p5  = longint'(offs_cal[15:0]);
    p6  = longint'(offs_cal[31:16]);
    p7  = longint'($signed(offs_cal[39:32]));
    p8  = longint'($signed(offs_cal[47:40]));
    p9  = longint'($signed(high_cal[15:0]));
    p10 = longint'($signed(high_cal[23:16]));
    p11 = longint'($signed(high_cal[31:24]));
    u   = longint'(s.raw_pressure);
    d   = longint'(s.raw_temperature) - 256 * t1;
    tn  = d * t2 * 262144 + d * d * t3;
    tl  = (tn + 64'sd2147483648) >>> 32;
    tl2 = tl * tl;
    u2  = u * u;
    tl3 = wide_t'(tl2) * wide_t'(tl);
    // Sum over a common denominator of 2^85
    acc = (wide_t'(p5) <<< 88)
        + (wide_t'(p6 * tl) <<< 63)
        + (wide_t'(p7 * tl2) <<< 45)
        + ((wide_t'(p8) * tl3) <<< 22)
        + (wide_t'(u * p1) <<< 65)
        + ((wide_t'(u * p2) * wide_t'(tl)) <<< 40)
        + ((wide_t'(u * p3) * wide_t'(tl2)) <<< 21)
        + (wide_t'(u * p4) * tl3)
        + ((wide_t'(u2) * wide_t'(p9)) <<< 37)
        + ((wide_t'(u2 * p10) * wide_t'(tl)) <<< 21)
        + ((wide_t'(u2) * wide_t'(u * p11)) <<< 20);
    // Round to 1/256 Pa, ties upward
    pres = (acc + (wide_t'(1) <<< 76)) >>> 77;
    clip = 1'b0;
    if (tl > 8388607) begin
      tl = 8388607;
      clip = 1'b1;
    end
    if (tl < -8388608) begin
      tl = -8388608;
      clip = 1'b1;
    end
    if (pres > wide_t'(33554431)) begin
      pres = 33554431;
      clip = 1'b1;
    end
    if (pres < 0) begin
      pres = 0;
      clip = 1'b1;
    end
    r.temperature_out = tl[23:0];
    r.pressure_out    = pres[24:0];
    r.clamped         = clip;
    return r;
  endfunction

  // Result side: random stall
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= gaps_on && ($urandom_range(0, 99) < 17);
  end

  // Compare each result transaction with the oldest prediction; run watchdog
  always @(negedge clk) begin
    out_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result transaction %h", out_data);
        end else begin
          want = expected_results.pop_front();
          if (want.temperature_out !== out_data.temperature_out ||
              want.pressure_out !== out_data.pressure_out ||
              want.clamped !== out_data.clamped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected temp %0d pres %0d clamp %0b, got %0d %0d %0b",
                       want.temperature_out, want.pressure_out, want.clamped,
                       out_data.temperature_out, out_data.pressure_out, out_data.clamped);
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Send one sample pair; called right after a rising edge
  task automatic send_sample(logic [23:0] pres_raw, logic [23:0] temp_raw);
    in_t s;
    while (gaps_on && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    s.raw_pressure    = pres_raw;
    s.raw_temperature = temp_raw;
    in_valid <= 1'b1;
    in_data  <= s;
    do @(negedge clk); while (in_stall);
    expected_results.push_back(compensate(s));
    @(posedge clk);
  endtask

  // Drain the pipeline, then load all four calibration registers
  task automatic load_calibration(logic [39:0] tc, logic [47:0] pg, logic [47:0] po,
                                  logic [31:0] ph);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_TEMP;
    cfg_data  <= {8'h00, tc};
    @(posedge clk);
    cfg_index <= CFG_PRESS_GAIN;
    cfg_data  <= pg;
    @(posedge clk);
    cfg_index <= CFG_PRESS_OFFS;
    cfg_data  <= po;
    @(posedge clk);
    cfg_index <= CFG_PRESS_HIGH;
    cfg_data  <= {16'h0000, ph};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    temp_cal = tc;
    gain_cal = pg;
    offs_cal = po;
    high_cal = ph;
  endtask

  // Typical factory calibration, plausible readings around it
  localparam logic [39:0] TYP_TC = {8'hF9, 16'd19000, 16'd27500};
  localparam logic [47:0] TYP_PG = {8'h00, 8'd30, 16'hF060, 16'hF448};
  localparam logic [47:0] TYP_PO = {8'hFB, 8'h03, 16'd30000, 16'd25000};
  localparam logic [31:0] TYP_PH = {8'hC4, 8'h0A, 16'd16000};

  task automatic test_reset_calibration();
    // Registers are zero after reset
    send_sample(24'h000000, 24'h000000);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h800000, 24'h7FFFFF);
  endtask

  task automatic test_field_extremes();
    load_calibration(TYP_TC, TYP_PG, TYP_PO, TYP_PH);
    send_sample(24'h000000, 24'h000000);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h000000, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'h000000);
    send_sample(24'h555555, 24'hAAAAAA);
    send_sample(24'hAAAAAA, 24'h555555);
    // Raw temperature exactly at 256*T1, and either side of it
    send_sample(24'h700000, 24'd7040000);
    send_sample(24'h700000, 24'd7039999);
    send_sample(24'h700000, 24'd7040001);
    send_sample(24'h6A0000, 24'h6B0000);
  endtask

  task automatic test_calibration_extremes();
    load_calibration('1, '1, '1, '1);
    send_sample(24'h000000, 24'h000000);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h123456, 24'hFEDCBA);
    load_calibration({8'h7F, 16'hFFFF, 16'h0000}, {8'h7F, 8'h7F, 16'h7FFF, 16'h7FFF},
                     {8'h7F, 8'h7F, 16'hFFFF, 16'hFFFF}, {8'h7F, 8'h7F, 16'h7FFF});
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h000001, 24'h000000);
    load_calibration({8'h80, 16'h0000, 16'hFFFF}, {8'h80, 8'h80, 16'h8000, 16'h8000},
                     {8'h80, 8'h80, 16'h0000, 16'h0000}, {8'h80, 8'h80, 16'h8000});
    send_sample(24'hFFFFFF, 24'h000000);
    send_sample(24'h000000, 24'hFFFFFF);
  endtask

  task automatic test_random_samples();
    logic [39:0] tc;
    logic [47:0] pg, po;
    logic [31:0] ph;
    int base_t;
    for (int phase = 0; phase < 6; phase++) begin
      // Alternate plausible calibrations with fully random ones
      if (phase % 2 == 0) begin
        tc = TYP_TC ^ {8'($urandom_range(0, 255)), 16'($urandom_range(0, 4095)),
                       16'($urandom_range(0, 4095))};
        pg = TYP_PG ^ {8'h00, 8'($urandom_range(0, 15)), 16'(1 + $urandom_range(0, 255)),
                       16'($urandom_range(0, 511))};
        po = TYP_PO ^ {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                       16'($urandom_range(0, 2047)), 16'($urandom_range(0, 2047))};
        ph = TYP_PH ^ {8'($urandom_range(0, 15)), 8'($urandom_range(0, 7)),
                       16'($urandom_range(0, 1023))};
      end else begin
        tc = 40'({$urandom(), $urandom()});
        pg = 48'({$urandom(), $urandom()});
        po = 48'({$urandom(), $urandom()});
        ph = $urandom();
      end
      load_calibration(tc, pg, po, ph);
      base_t = 256 * int'(tc[15:0]);
      gaps_on = (phase != 3);
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 99) < 60)
          send_sample(24'($urandom_range(4000000, 9000000)),
                      24'(base_t + int'($urandom_range(0, 2000000)) - 1000000));
        else
          send_sample(24'($urandom()), 24'($urandom()));
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = CFG_TEMP;
    cfg_data   = '0;
    temp_cal   = '0;
    gain_cal   = '0;
    offs_cal   = '0;
    high_cal   = '0;
    mismatches = 0;
    quiet_cycles = 0;
    gaps_on    = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_calibration();
    test_field_extremes();
    test_calibration_extremes();
    test_random_samples();

    // Drain and let the pipeline settle
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: baro_temp_pressure_compensation.f
sv/btpc_pkg.sv
sv/btpc_wmul.sv
sv/baro_temp_pressure_compensation.sv
test/testbench.sv
